@@ rtl/record_key_sorter_assert.svh @@
// ----------------------------------------------------------------------------
// record_key_sorter assertion macros
// Shared property forms for the record key sorter checkers.
// ----------------------------------------------------------------------------
`ifndef RECORD_KEY_SORTER_ASSERT_SVH
`define RECORD_KEY_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RKS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("record_key_sorter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("record_key_sorter assertion failed");

`endif

@@ rtl/rks_pkg.sv @@
// ----------------------------------------------------------------------------
// rks_pkg
// Types and fixed widths shared by the record key sorter modules.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int unsigned InKeyBits  = 32;
  localparam int unsigned OutKeyBits = 32;
  localparam int unsigned IdxBits    = 6;
  localparam int unsigned OutTdataBits = 40;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift_down;
    logic shift_up;
  } cell_ctrl_t;

endpackage

@@ rtl/rks_cell.sv @@
// ----------------------------------------------------------------------------
// rks_cell
// One slot of the insertion chain: holds a key and its arrival index.
// ----------------------------------------------------------------------------
module rks_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rks_pkg::cell_ctrl_t        ctrl_i,
  input  logic [KEY_BITS-1:0]        new_key_i,
  input  logic [rks_pkg::IdxBits-1:0] new_idx_i,
  input  logic                       lo_valid_i,
  input  logic [KEY_BITS-1:0]        lo_key_i,
  input  logic [rks_pkg::IdxBits-1:0] lo_idx_i,
  input  logic                       lo_gt_i,
  input  logic                       hi_valid_i,
  input  logic [KEY_BITS-1:0]        hi_key_i,
  input  logic [rks_pkg::IdxBits-1:0] hi_idx_i,
  output logic                       valid_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [rks_pkg::IdxBits-1:0] idx_o,
  output logic                       gt_o
);

  logic                        valid_q, valid_d;
  logic [KEY_BITS-1:0]         key_q, key_d;
  logic [rks_pkg::IdxBits-1:0] idx_q, idx_d;
  logic                        gt;

  // An empty slot counts as greater, so a key that no stored key exceeds lands in the first free one.
  assign gt = !valid_q || (key_q > new_key_i);

  always_comb begin
    priority if (ctrl_i.insert && gt) begin
      if (lo_gt_i) begin
        valid_d = lo_valid_i;
        key_d   = lo_key_i;
        idx_d   = lo_idx_i;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        idx_d   = new_idx_i;
      end
    end else if (ctrl_i.shift_down) begin
      valid_d = hi_valid_i;
      key_d   = hi_key_i;
      idx_d   = hi_idx_i;
    end else if (ctrl_i.shift_up) begin
      valid_d = lo_valid_i;
      key_d   = lo_key_i;
      idx_d   = lo_idx_i;
    end else begin
      valid_d = valid_q;
      key_d   = key_q;
      idx_d   = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign idx_o   = idx_q;
  assign gt_o    = gt;

endmodule

@@ rtl/record_key_sorter.sv @@
// ----------------------------------------------------------------------------
// record_key_sorter
// Sort of a run of keys (stable in ascending order), returning each key with its arrival index.
// ----------------------------------------------------------------------------
// Keys arrive on the slave stream, one word per cycle, with tlast on the final
// key of a run. Each key is inserted into a chain of MAX_RECORDS cells as it
// is accepted, so loading runs at one word per cycle. Keys beyond MAX_RECORDS are
// dropped and every result of that run carries tuser = 1.
// After the last key the input closes and the chain drains. Ascending order
// shifts the chain down and emits one word per cycle while the receiver takes them.
// Descending order shifts the chain up and emits from the top cell, once the
// empty cells above the keys have shifted out. An output register holds each
// result; the final word carries tlast, and the input reopens as that word
// is loaded into the output register.
// The direction register is written through the cfg channel, always ready,
// and must only change while no run is in progress. Reset empties the chain,
// clears the output valid and selects ascending order.
// When the receiver stalls, the output word holds and the chain stops once
// its next word is in place; in descending order empty cells still shift up.
module record_key_sorter #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i,     // sort_descending
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rks_pkg::InKeyBits-1:0]       s_axis_tdata,   // key_value
  input  logic                                s_axis_tlast,   // last_key
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rks_pkg::OutTdataBits-1:0]    m_axis_tdata,   // sorted_key, source_index
  output logic                                m_axis_tlast,   // last_result
  output logic                                m_axis_tuser    // overflow
);

  localparam int unsigned CntBits = $clog2(MAX_RECORDS + 1);

  rks_pkg::state_e             state_q, state_d;
  logic [CntBits-1:0]          count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        desc_q;

  logic                        out_valid_q, out_valid_d;
  logic [rks_pkg::OutKeyBits-1:0] out_key_q, out_key_d;
  logic [rks_pkg::IdxBits-1:0] out_idx_q, out_idx_d;
  logic                        out_last_q, out_last_d;
  logic                        out_ovf_q, out_ovf_d;

  logic                        in_fire, full, emit_ok, emit;
  rks_pkg::cell_ctrl_t         ctrl;
  logic [KEY_BITS-1:0]         new_key;
  logic [rks_pkg::IdxBits-1:0] new_idx;

  logic                        cell_valid [MAX_RECORDS];
  logic [KEY_BITS-1:0]         cell_key   [MAX_RECORDS];
  logic [rks_pkg::IdxBits-1:0] cell_idx   [MAX_RECORDS];
  logic                        cell_gt    [MAX_RECORDS];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == rks_pkg::ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntBits'(MAX_RECORDS));
  assign new_key       = KEY_BITS'(s_axis_tdata);
  assign new_idx       = rks_pkg::IdxBits'(count_q);
  assign emit_ok       = !out_valid_q || m_axis_tready;

  always_comb begin
    ctrl        = '0;
    emit        = 1'b0;
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_key_d   = out_key_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      rks_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CntBits'(1);
          end
          if (s_axis_tlast) begin
            state_d = rks_pkg::ST_DRAIN;
          end
        end
      end
      rks_pkg::ST_DRAIN: begin
        if (desc_q) begin
          if (!cell_valid[MAX_RECORDS-1]) begin
            ctrl.shift_up = 1'b1;
          end else if (emit_ok) begin
            ctrl.shift_up = 1'b1;
            emit          = 1'b1;
            out_key_d     = rks_pkg::OutKeyBits'(cell_key[MAX_RECORDS-1]);
            out_idx_d     = cell_idx[MAX_RECORDS-1];
          end
        end else if (emit_ok) begin
          ctrl.shift_down = 1'b1;
          emit            = 1'b1;
          out_key_d       = rks_pkg::OutKeyBits'(cell_key[0]);
          out_idx_d       = cell_idx[0];
        end
        if (emit) begin
          out_valid_d = 1'b1;
          out_last_d  = (count_q == CntBits'(1));
          out_ovf_d   = ovf_q;
          count_d     = count_q - CntBits'(1);
          if (count_q == CntBits'(1)) begin
            state_d = rks_pkg::ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = rks_pkg::ST_LOAD;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic                        lo_valid, lo_gt, hi_valid;
    logic [KEY_BITS-1:0]         lo_key, hi_key;
    logic [rks_pkg::IdxBits-1:0] lo_idx, hi_idx;

    if (i == 0) begin : g_bottom
      assign lo_valid = 1'b0;
      assign lo_key   = '0;
      assign lo_idx   = '0;
      assign lo_gt    = 1'b0;
    end else begin : g_lower
      assign lo_valid = cell_valid[i-1];
      assign lo_key   = cell_key[i-1];
      assign lo_idx   = cell_idx[i-1];
      assign lo_gt    = cell_gt[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_top
      assign hi_valid = 1'b0;
      assign hi_key   = '0;
      assign hi_idx   = '0;
    end else begin : g_upper
      assign hi_valid = cell_valid[i+1];
      assign hi_key   = cell_key[i+1];
      assign hi_idx   = cell_idx[i+1];
    end

    rks_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_key_i  (new_key),
      .new_idx_i  (new_idx),
      .lo_valid_i (lo_valid),
      .lo_key_i   (lo_key),
      .lo_idx_i   (lo_idx),
      .lo_gt_i    (lo_gt),
      .hi_valid_i (hi_valid),
      .hi_key_i   (hi_key),
      .hi_idx_i   (hi_idx),
      .valid_o    (cell_valid[i]),
      .key_o      (cell_key[i]),
      .idx_o      (cell_idx[i]),
      .gt_o       (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rks_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        desc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_idx_q, out_key_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

@@ rtl/rks_checker.sv @@
// ----------------------------------------------------------------------------
// rks_checker
// Port-level checks on the record key sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_key_sorter_assert.svh"

module rks_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rks_pkg::OutTdataBits-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // A stalled output word holds its contents.
  `RKS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

  // The input stays closed while a run is still being emitted.
  `RKS_ASSERT_SAME(a_in_closed, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // The last key of a run closes the input.
  `RKS_ASSERT_NEXT(a_last_closes, s_axis_tvalid && s_axis_tready && s_axis_tlast,
                   !s_axis_tready)

  // Within a run the results leave without gaps once one has been taken.
  `RKS_ASSERT_NEXT(a_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   m_axis_tvalid)

endmodule

bind record_key_sorter rks_checker u_rks_checker (.*);
